@@ src/brc_pkg.sv @@
`default_nettype none
package brc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned OffW    = 5;
  localparam int unsigned PosW    = 28;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegStartOffset = 1'b0;
  localparam logic [CfgIdxW-1:0] RegBitCount    = 1'b1;

  localparam logic [WordW-1:0] AllOnes = {WordW{1'b1}};

  // range geometry, precomputed whenever a register is written
  typedef struct packed {
    logic             count_zero;
    logic             single;
    logic [PosW-1:0]  last_idx;
    logic [WordW-1:0] single_mask;
    logic [WordW-1:0] first_mask;
    logic [WordW-1:0] tail_mask;
  } geom_t;

  function automatic logic [WordW-1:0] low_ones(input logic [OffW-1:0] n);
    low_ones = (32'h1 << n) - 32'h1;
  endfunction

  function automatic logic [5:0] pop32(input logic [WordW-1:0] w);
    logic [WordW-1:0] v;
    v = w - ((w >> 1) & 32'h5555_5555);
    v = ((v >> 2) & 32'h3333_3333) + (v & 32'h3333_3333);
    v = ((v >> 4) + v) & 32'h0f0f_0f0f;
    v = v + (v >> 8);
    v = v + (v >> 16);
    pop32 = v[5:0] & 6'h3f;
  endfunction

  function automatic geom_t calc_geom(input logic [OffW-1:0] off,
                                      input logic [WordW-1:0] cnt);
    logic [WordW:0]   span;
    logic [WordW+1:0] nwords;
    logic [WordW+1:0] last;
    logic [OffW-1:0]  tail;
    geom_t            g;
    span   = {{(WordW+1-OffW){1'b0}}, off} + {1'b0, cnt};
    nwords = ({1'b0, span} + 34'd31) >> 5;
    last   = nwords - 34'd1;
    tail   = span[OffW-1:0];
    g.count_zero  = (cnt == '0);
    g.single      = (nwords == 34'd1);
    g.last_idx    = last[PosW-1:0];
    g.single_mask = ((cnt >= 32'd32) ? AllOnes : low_ones(cnt[OffW-1:0])) << off;
    g.first_mask  = AllOnes << off;
    g.tail_mask   = (tail == '0) ? AllOnes : low_ones(tail);
    calc_geom = g;
  endfunction

endpackage
`default_nettype wire

@@ src/bit_range_count_and_test.sv @@
`default_nettype none
// Bit range population count and any-zero / any-one test. Program
// start_offset (index 0) and bit_count (index 1) while the block is idle,
// then stream the range's words lowest bit first; one result request
// (ones_total, has_zero, has_one) comes out on the range's last word, and
// the accumulators clear for the next range. With bit_count zero every
// word yields a result of all zeros. The block takes one word per cycle
// while the result register is empty or being drained: a word is held in
// the input register, then a single masked popcount and 32-bit add move
// it into the accumulators or the result register. The range geometry
// (word count, masks) is computed at register-write time, so the per-word
// path holds only the mask select, popcount and add. The input register
// advances whenever the result register is empty or being drained.
module bit_range_count_and_test
  import brc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [WordW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [WordW-1:0]   data_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [WordW-1:0]        ones_total_o,
  output logic                    has_zero_o,
  output logic                    has_one_o
);

  // configuration and derived geometry
  logic [OffW-1:0]  offset_q, offset_d;
  logic [WordW-1:0] count_q, count_d;
  geom_t            geom_q;

  // input stage
  logic             s1_valid_q;
  logic [WordW-1:0] word_q;
  logic             s1_adv;

  // accumulators
  logic [PosW-1:0]  pos_q, pos_d;
  logic [WordW-1:0] run_q, run_d;
  logic             zseen_q, zseen_d;
  logic             oseen_q, oseen_d;

  // result register
  logic             out_valid_q;
  logic [WordW-1:0] out_ones_q;
  logic             out_zero_q, out_one_q;

  logic             emit;
  logic             last;
  logic [WordW-1:0] mask, sel, sum;
  logic             zero_now, one_now;

  // Stage the new register value next to the other one.
  always_comb begin
    offset_d = offset_q;
    count_d  = count_q;
    case (cfg_index_i)
      RegStartOffset: offset_d = cfg_data_i[OffW-1:0];
      RegBitCount:    count_d  = cfg_data_i;
      default:        ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      count_q  <= '0;
      geom_q   <= calc_geom('0, '0);
    end else if (cfg_we_i) begin
      offset_q <= offset_d;
      count_q  <= count_d;
      geom_q   <= calc_geom(offset_d, count_d);
    end
  end

  // Advance the input stage when the result slot is free or draining.
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= data_word_i;
    end
  end

  // Pick the mask for this word's place in the range.
  always_comb begin
    last = (pos_q >= geom_q.last_idx);
    if (geom_q.single) begin
      mask = geom_q.single_mask;
    end else if (last) begin
      mask = geom_q.tail_mask;
    end else if (pos_q == '0) begin
      mask = geom_q.first_mask;
    end else begin
      mask = AllOnes;
    end
    sel      = word_q & mask;
    sum      = run_q + {{(WordW-6){1'b0}}, pop32(sel)};
    zero_now = zseen_q | (sel != mask);
    one_now  = oseen_q | (sel != '0);
  end

  // Accumulate, or emit and clear on the last word (on every word when the count is zero).
  always_comb begin
    pos_d   = pos_q;
    run_d   = run_q;
    zseen_d = zseen_q;
    oseen_d = oseen_q;
    emit    = 1'b0;
    if (s1_valid_q && s1_adv) begin
      if (geom_q.count_zero || last) begin
        emit    = 1'b1;
        pos_d   = '0;
        run_d   = '0;
        zseen_d = 1'b0;
        oseen_d = 1'b0;
      end else begin
        pos_d   = pos_q + 28'd1;
        run_d   = sum;
        zseen_d = zero_now;
        oseen_d = one_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      run_q       <= '0;
      zseen_q     <= 1'b0;
      oseen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      run_q   <= run_d;
      zseen_q <= zseen_d;
      oseen_q <= oseen_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the request is taken.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (geom_q.count_zero) begin
        out_ones_q <= '0;
        out_zero_q <= 1'b0;
        out_one_q  <= 1'b0;
      end else begin
        out_ones_q <= sum;
        out_zero_q <= zero_now;
        out_one_q  <= one_now;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ones_total_o = out_ones_q;
  assign has_zero_o   = out_zero_q;
  assign has_one_o    = out_one_q;

endmodule
`default_nettype wire

@@ tb/tb_bit_range_count_and_test.sv @@
`default_nettype none
module tb_bit_range_count_and_test;
  import brc_pkg::*;

  localparam int unsigned RandomWords  = 650;
  localparam int unsigned CycleLimit   = 300000;
  // Let the input and result registers empty out before a register write.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LongHold     = 200;

  typedef struct packed {
    logic [WordW-1:0] ones_total;
    logic             has_zero;
    logic             has_one;
  } range_result_t;

  // Tracks the range geometry and the running count, and holds the results
  // still owed by the block in arrival order.
  class range_scoreboard;
    logic [OffW-1:0]  offset;
    logic [WordW-1:0] count;
    logic [PosW-1:0]  word_pos;
    logic [WordW-1:0] ones_acc;
    logic             zero_acc;
    logic             one_acc;
    range_result_t    owed_q[$];
    int unsigned      failures;

    function new();
      offset   = '0;
      count    = '0;
      failures = 0;
      clear_range();
    endfunction

    function void clear_range();
      word_pos = '0;
      ones_acc = '0;
      zero_acc = 1'b0;
      one_acc  = 1'b0;
    endfunction

    function void set_regs(input logic [OffW-1:0] off, input logic [WordW-1:0] cnt);
      offset = off;
      count  = cnt;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_word(input logic [WordW-1:0] w);
      logic [63:0]      span;
      logic [63:0]      nwords;
      logic [OffW-1:0]  tail;
      logic [WordW-1:0] mask;
      logic [WordW-1:0] sel;
      logic             last;
      range_result_t    res;
      if (count == '0) begin
        clear_range();
        owed_q.push_back('0);
        return;
      end
      span   = 64'(offset) + 64'(count);
      nwords = (span + 64'd31) >> 5;
      tail   = span[OffW-1:0];
      last   = (64'(word_pos) + 64'd1 >= nwords);
      if (nwords == 64'd1) begin
        mask = (count >= 32'd32) ? AllOnes : ((32'h1 << count[OffW-1:0]) - 32'h1);
        mask = mask << offset;
      end else if (last) begin
        mask = (tail == '0) ? AllOnes : ((32'h1 << tail) - 32'h1);
      end else if (word_pos == '0) begin
        mask = AllOnes << offset;
      end else begin
        mask = AllOnes;
      end
      sel      = w & mask;
      ones_acc = ones_acc + WordW'($countones(sel));
      if (sel != mask) zero_acc = 1'b1;
      if (sel != '0) one_acc = 1'b1;
      if (last) begin
        res.ones_total = ones_acc;
        res.has_zero   = zero_acc;
        res.has_one    = one_acc;
        owed_q.push_back(res);
        clear_range();
      end else begin
        word_pos = word_pos + 1'b1;
      end
    endfunction

    function void check_result(input logic [WordW-1:0] ones, input logic hz,
                               input logic ho);
      range_result_t want;
      if (owed_q.size() == 0) begin
        $error("result with none owed: ones_total %0d has_zero %0b has_one %0b",
               ones, hz, ho);
        failures++;
        return;
      end
      want = owed_q.pop_front();
      if (ones !== want.ones_total) begin
        $error("ones_total: expected %0d, got %0d", want.ones_total, ones);
        failures++;
      end
      if (hz !== want.has_zero) begin
        $error("has_zero: expected %0b, got %0b", want.has_zero, hz);
        failures++;
      end
      if (ho !== want.has_one) begin
        $error("has_one: expected %0b, got %0b", want.has_one, ho);
        failures++;
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = RegStartOffset;
  logic [WordW-1:0]    cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [WordW-1:0]    data_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [WordW-1:0]    ones_total_o;
  logic                has_zero_o;
  logic                has_one_o;

  range_scoreboard     sb;
  int unsigned         words_sent    = 0;
  int unsigned         cycle_count   = 0;
  // Shared with the receiver: a pending hold-off length and a no-gap mode.
  int unsigned         rx_hold_cycles = 0;
  bit                  steady        = 1'b0;

  bit_range_count_and_test DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ones_total_o (ones_total_o),
    .has_zero_o   (has_zero_o),
    .has_one_o    (has_one_o)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run; a hang or a missing result ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly zero, often short, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias the data toward all-clear, all-set and lone-bit words.
  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return AllOnes;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  // Number of words one range occupies; a zero count answers every word.
  function automatic logic [63:0] range_words(input logic [OffW-1:0] off,
                                              input logic [WordW-1:0] cnt);
    if (cnt == '0) return 64'd1;
    return (64'(off) + 64'(cnt) + 64'd31) >> 5;
  endfunction

  // Result side: take every result request that the block offers while ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(ones_total_o, has_zero_o, has_one_o);
  end

  // Receiver: stall at random, drop ready for a long stretch on demand, and
  // hold ready high while the no-gap mode is on.
  initial begin : receiver
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        held           = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready_i   <= 1'b0;
        repeat (held) @(posedge clk_i);
        out_ready_i   <= 1'b1;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
    end
  end

  // Offer one word after a random gap, none in no-gap mode, and hold it until the request is taken.
  // Keep valid high across back-to-back words: lower it only for a real gap.
  task automatic send_word(input logic [WordW-1:0] w);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    words_sent++;
  endtask

  // Stop offering, wait for every owed result, then let the pipeline drain
  // of words that complete no range.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both registers on consecutive edges; call only after settle.
  task automatic write_cfg(input logic [OffW-1:0] off, input logic [WordW-1:0] cnt);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegStartOffset;
    cfg_data_i  <= WordW'(off);
    @(posedge clk_i);
    cfg_index_i <= RegBitCount;
    cfg_data_i  <= cnt;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_regs(off, cnt);
  endtask

  initial begin : stimulus
    logic [OffW-1:0]  off;
    logic [WordW-1:0] cnt;
    logic [63:0]      span_words;
    int unsigned      n;
    int unsigned      cap;
    int unsigned      random_base;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers give a zero count: every word answers with zeros.
    send_word(AllOnes);
    send_word('0);

    // One full word at offset zero.
    settle();
    write_cfg(5'd0, 32'd32);
    send_word(AllOnes);
    send_word('0);
    send_word(32'hA5A5_A5A5);

    // A single bit at the top of the word.
    settle();
    write_cfg(5'd31, 32'd1);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);

    // A window in the middle of one word, all of it set.
    settle();
    write_cfg(5'd5, 32'd10);
    send_word(32'h0000_7FE0);

    // Two words where the range ends on a word boundary: last word taken whole.
    settle();
    write_cfg(5'd31, 32'd33);
    send_word(32'h8000_0000);
    send_word(AllOnes);

    // First, middle and tail masks in one range.
    settle();
    write_cfg(5'd3, 32'd100);
    repeat (4) send_word(rand_word());

    // Largest count, then shrink it mid-range: the next word closes the range
    // with the tail mask and keeps what was counted so far.
    settle();
    write_cfg(5'd0, AllOnes);
    repeat (3) send_word(AllOnes);
    settle();
    write_cfg(5'd0, 32'd40);
    send_word(AllOnes);

    // Largest offset and count, then drop the count to zero mid-range.
    settle();
    write_cfg(5'd31, AllOnes);
    repeat (2) send_word(AllOnes);
    settle();
    write_cfg(5'd31, 32'd0);
    send_word(AllOnes);

    // Backpressure: hold off the result side while words keep coming, so the
    // block fills and drops in_ready; settle then waits for the backlog.
    settle();
    write_cfg(5'd7, 32'd0);
    random_base    = words_sent;
    steady         = 1'b1;
    rx_hold_cycles = LongHold;
    repeat (40) send_word(rand_word());
    steady         = 1'b0;

    // Random phases: mostly whole ranges, sometimes a range cut short so the
    // next register write lands mid-range.
    while (words_sent < random_base + RandomWords) begin
      settle();
      case ($urandom_range(0, 9))
        0:       off = 5'd0;
        1:       off = 5'd31;
        default: off = OffW'($urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 19))
        0:       cnt = '0;
        1:       cnt = 32'd32 * $urandom_range(1, 4) - WordW'(off);
        2:       cnt = $urandom_range(33, 300);
        3:       cnt = $urandom();
        default: cnt = $urandom_range(1, 96);
      endcase
      if (cnt == '0 && $urandom_range(0, 1) == 0) cnt = 32'd1;
      write_cfg(off, cnt);
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 29) == 0) rx_hold_cycles = LongHold;
      span_words = range_words(off, cnt);
      if (span_words > 64'd6 || (span_words > 64'd1 && $urandom_range(0, 7) == 0)) begin
        cap = (span_words > 64'd6) ? 6 : int'(span_words) - 1;
        n   = $urandom_range(1, cap);
      end else begin
        n = int'(span_words) * $urandom_range(1, 4);
      end
      repeat (n) send_word(rand_word());
      steady = 1'b0;
    end

    // Drain and give the block time to show any stray result.
    settle();
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
